// ===== src/lcrt_pkg.sv =====
// ----------------------------------------------------------------------------
// lcrt_pkg
// Shared widths and defaults for the longest consecutive run tracker.
// ----------------------------------------------------------------------------
package lcrt_pkg;

  // fixed field widths of the item and result beats
  localparam int ValueW   = 10;
  localparam int LongestW = 11;

  // default value window
  localparam int VALUE_BITS_DEF = 10;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

endpackage

// ===== src/lcrt_ram.sv =====
// ----------------------------------------------------------------------------
// lcrt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lcrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/longest_consecutive_run_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// longest_consecutive_run_tracker_unit
// Tracks the longest run of consecutive values inserted since the last clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: in_action
//   selects insert or clear, in_value is the value to insert. The result
//   channel (out_valid/out_ready) returns one beat per item: the longest run
//   after the item and whether the inserted value was new.
//   Run lengths live in one RAM of 2^VALUE_BITS entries; every access goes
//   through its single read port and single write port, one per cycle.
//   Steps from input beat to result beat:
//     new value      : three reads, three writes, result load
//     duplicate      : self read, result load
//     outside window : result load
//     clear          : every entry zeroed, one entry per cycle, then result load
//   One item is in flight at a time; in_ready is high only while idle, so
//   the next input beat can be taken in the cycle after the result loads.
//   After reset the block zeroes all 2^VALUE_BITS RAM entries with
//   in_ready low and no result beat.
//   A finished result sits in the output register; the next item is taken
//   meanwhile and only its final step waits while out_ready is low.
// ----------------------------------------------------------------------------
module longest_consecutive_run_tracker_unit
  import lcrt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic [ValueW-1:0]   in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LongestW-1:0] out_longest_run,
  output logic                out_was_new
);

  localparam int Depth = 1 << VALUE_BITS;
  localparam int LenW  = VALUE_BITS + 1;
  localparam int ExtW  = (VALUE_BITS > ValueW) ? VALUE_BITS : ValueW;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RD_L    = 9'b000000010,
    S_RD_R    = 9'b000000100,
    S_CALC    = 9'b000001000,
    S_WR_SELF = 9'b000010000,
    S_WR_LO   = 9'b000100000,
    S_WR_HI   = 9'b001000000,
    S_CLR     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                  clr_report_r, clr_report_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [LenW-1:0]       longest_r, longest_nxt;

  logic [VALUE_BITS-1:0] idx_r, idx_nxt;
  logic [LenW-1:0]       left_r, left_nxt;
  logic [LenW-1:0]       right_r, right_nxt;
  logic [LenW-1:0]       len_r, len_nxt;
  logic [VALUE_BITS-1:0] lo_r, lo_nxt;
  logic [VALUE_BITS-1:0] hi_r, hi_nxt;
  logic                  was_new_r, was_new_nxt;
  logic [LongestW-1:0]   out_longest_r, out_longest_nxt;
  logic                  out_was_new_r, out_was_new_nxt;

  logic [ExtW-1:0]       value_ext;
  logic                  in_window;
  logic                  accept;
  logic                  load_out;
  logic [LenW-1:0]       len_sum;
  logic [LenW-1:0]       right_lim;

  logic                  ram_we;
  logic [VALUE_BITS-1:0] ram_waddr;
  logic [LenW-1:0]       ram_wdata;
  logic [VALUE_BITS-1:0] ram_raddr;
  logic [LenW-1:0]       ram_rdata;

  lcrt_ram #(
    .WIDTH (LenW),
    .DEPTH (Depth)
  ) u_run_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign value_ext = ExtW'(in_value);
  assign in_window = (value_ext >> VALUE_BITS) == '0;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign len_sum   = left_r + right_r + LenW'(1);
  // room to the right of idx is WINDOW_MASK - idx, which is ~idx
  assign right_lim = {1'b0, ~idx_r};

  assign out_valid       = out_valid_r;
  assign out_longest_run = out_longest_r;
  assign out_was_new     = out_was_new_r;

  // read address: self on accept, then left and right neighbors
  always_comb begin
    case (state_r)
      S_IDLE:  ram_raddr = value_ext[VALUE_BITS-1:0];
      S_RD_L:  ram_raddr = idx_r - VALUE_BITS'(1);
      S_RD_R:  ram_raddr = idx_r + VALUE_BITS'(1);
      default: ram_raddr = idx_r;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = len_r;
    case (state_r)
      S_WR_SELF: begin
        ram_we    = 1'b1;
        ram_wdata = len_sum;
      end
      S_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
      end
      S_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    clr_report_nxt  = clr_report_r;
    longest_nxt     = longest_r;
    idx_nxt         = idx_r;
    left_nxt        = left_r;
    right_nxt       = right_r;
    len_nxt         = len_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    was_new_nxt     = was_new_r;
    out_longest_nxt = out_longest_r;
    out_was_new_nxt = out_was_new_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt     = value_ext[VALUE_BITS-1:0];
          was_new_nxt = 1'b0;
          if (in_action == ACT_CLEAR) begin
            clr_cnt_nxt    = '0;
            clr_report_nxt = 1'b1;
            state_nxt      = S_CLR;
          end else if (!in_window) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD_L;
          end
        end
      end
      S_RD_L: begin
        // self entry arrives: nonzero means already present
        if (ram_rdata != '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD_R;
        end
      end
      S_RD_R: begin
        // left neighbor arrives; drop it at the low edge, clamp to window
        if (idx_r == '0) begin
          left_nxt = '0;
        end else if (ram_rdata > LenW'(idx_r)) begin
          left_nxt = LenW'(idx_r);
        end else begin
          left_nxt = ram_rdata;
        end
        state_nxt = S_CALC;
      end
      S_CALC: begin
        // right neighbor arrives; drop it at the high edge, clamp to window
        if (idx_r == '1) begin
          right_nxt = '0;
        end else if (ram_rdata > right_lim) begin
          right_nxt = right_lim;
        end else begin
          right_nxt = ram_rdata;
        end
        state_nxt = S_WR_SELF;
      end
      S_WR_SELF: begin
        len_nxt   = len_sum;
        lo_nxt    = idx_r - left_r[VALUE_BITS-1:0];
        hi_nxt    = idx_r + right_r[VALUE_BITS-1:0];
        state_nxt = S_WR_LO;
      end
      S_WR_LO: begin
        state_nxt = S_WR_HI;
      end
      S_WR_HI: begin
        if (len_r > longest_r) begin
          longest_nxt = len_r;
        end
        was_new_nxt = 1'b1;
        state_nxt   = S_DONE;
      end
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + VALUE_BITS'(1);
        if (clr_cnt_r == '1) begin
          longest_nxt = '0;
          state_nxt   = clr_report_r ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (load_out) begin
          out_valid_nxt   = 1'b1;
          out_longest_nxt = LongestW'(longest_r);
          out_was_new_nxt = was_new_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
      longest_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
      longest_r    <= longest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    left_r        <= left_nxt;
    right_r       <= right_nxt;
    len_r         <= len_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    was_new_r     <= was_new_nxt;
    out_longest_r <= out_longest_nxt;
    out_was_new_r <= out_was_new_nxt;
  end

endmodule

// ===== src/lcrt_checker.sv =====
// ----------------------------------------------------------------------------
// lcrt_checker
// Port-level checks for the longest consecutive run tracker.
// ----------------------------------------------------------------------------
module lcrt_checker
  import lcrt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_action,
  input logic [ValueW-1:0]   in_value,
  input logic                out_valid,
  input logic                out_ready,
  input logic [LongestW-1:0] out_longest_run,
  input logic                out_was_new
);

  localparam logic NoWrap = (VALUE_BITS < LongestW);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_longest_run)
      && $stable(out_was_new))
    else $error("result beat changed while stalled");

  // a waiting input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_action)
      && $stable(in_value))
    else $error("input beat changed while waiting");

  // one item at a time: an accepted beat closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // a new value always leaves a run of at least one; checked when VALUE_BITS < LongestW
  a_new_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_new && NoWrap |-> out_longest_run != '0)
    else $error("new value reported with empty longest run");

  // reset sweep: no input taken and no result shown
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind longest_consecutive_run_tracker_unit lcrt_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_lcrt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_action       (in_action),
  .in_value        (in_value),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_longest_run (out_longest_run),
  .out_was_new     (out_was_new)
);

// ===== tb/tb_longest_consecutive_run_tracker_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_longest_consecutive_run_tracker_unit
// Drives insert and clear beats into the run tracker and checks every result
// beat against an in-bench model of the run-length table, or a typed row's
// own result. A short directed table covers the window edges, duplicates and
// clears. The random part builds runs in narrow value bands, and one pass
// fills the whole window in shuffled order. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_longest_consecutive_run_tracker_unit;
  import lcrt_pkg::*;

  localparam int WinBits    = VALUE_BITS_DEF;
  localparam int Window     = 1 << WinBits;
  localparam int WinMask    = Window - 1;
  localparam int BandW      = 48;
  localparam int StallLimit = 8000;
  localparam int HoldCycles = 200;
  localparam int NDir       = 23;

  typedef struct packed {
    logic [LongestW-1:0] longest;
    logic                was_new;
  } run_result_t;

  typedef struct packed {
    logic               act;
    logic [ValueW-1:0]  val;
    logic               typed;
    logic [LongestW-1:0] want_len;
    logic               want_new;
  } dir_row_t;

  // typed rows carry their result; the rest go through the model
  localparam dir_row_t DirRows [NDir] = '{
    '{ACT_INSERT, 10'd0,    1'b1, 11'd1, 1'b1},
    '{ACT_INSERT, 10'd1023, 1'b1, 11'd1, 1'b1},
    '{ACT_INSERT, 10'd0,    1'b1, 11'd1, 1'b0},
    '{ACT_INSERT, 10'd1,    1'b1, 11'd2, 1'b1},
    '{ACT_INSERT, 10'd1022, 1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd2,    1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd1021, 1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd512,  1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd514,  1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd513,  1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd511,  1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd1023, 1'b0, 11'd0, 1'b0},
    '{ACT_CLEAR,  10'd1023, 1'b1, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd1023, 1'b1, 11'd1, 1'b1},
    '{ACT_INSERT, 10'd1022, 1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd341,  1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd682,  1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd340,  1'b0, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd342,  1'b0, 11'd0, 1'b0},
    '{ACT_CLEAR,  10'd0,    1'b1, 11'd0, 1'b0},
    '{ACT_CLEAR,  10'd0,    1'b1, 11'd0, 1'b0},
    '{ACT_INSERT, 10'd0,    1'b1, 11'd1, 1'b1},
    '{ACT_INSERT, 10'd1,    1'b0, 11'd0, 1'b0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_action = ACT_INSERT;
  logic [ValueW-1:0]   in_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LongestW-1:0] out_longest_run;
  logic                out_was_new;

  longest_consecutive_run_tracker_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_longest_run(out_longest_run),
    .out_was_new    (out_was_new)
  );

  // model state: run length per value, exact only at run ends
  logic [WinBits:0] run_len [Window];
  logic [WinBits:0] longest_seen;
  run_result_t      pending_runs [$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned beats_out = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (run_len[i]) run_len[i] = '0;
    longest_seen = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic run_result_t next_run_result(logic act, logic [ValueW-1:0] val);
    run_result_t r;
    int unsigned idx, lft, rgt, len;
    r.was_new = 1'b0;
    if (act == ACT_CLEAR) begin
      foreach (run_len[i]) run_len[i] = '0;
      longest_seen = '0;
    end else if (val <= WinMask) begin
      idx = 32'(val);
      if (run_len[idx] == 0) begin
        lft = (idx > 0) ? 32'(run_len[idx - 1]) : 0;
        rgt = (idx < WinMask) ? 32'(run_len[idx + 1]) : 0;
        // a merged run stays inside the window
        if (lft > idx) lft = idx;
        if (rgt > WinMask - idx) rgt = WinMask - idx;
        len = lft + rgt + 1;
        run_len[idx] = (WinBits + 1)'(len);
        run_len[idx - lft] = (WinBits + 1)'(len);
        run_len[idx + rgt] = (WinBits + 1)'(len);
        if (len > longest_seen) longest_seen = (WinBits + 1)'(len);
        r.was_new = 1'b1;
      end
    end
    r.longest = LongestW'(longest_seen);
    return r;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // offer one beat and hold it until taken; record its expected result
  task automatic offer_item(input logic act, input logic [ValueW-1:0] val,
                            input logic typed, input run_result_t typed_res);
    run_result_t res;
    bit steady;
    steady = (items_sent >= 600 && items_sent < 900);
    if (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
    res = next_run_result(act, val);
    pending_runs.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic run_mixed(input int unsigned n);
    int unsigned base, k, pick;
    logic [ValueW-1:0] v, recent;
    base = 0;
    recent = '0;
    for (k = 0; k < n; k++) begin
      // move the band now and then, sometimes onto a window edge
      if (k % 60 == 0) begin
        case ($urandom_range(3))
          0: base = 0;
          1: base = Window - BandW;
          default: base = $urandom_range(Window - BandW);
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 1) begin
        offer_item(ACT_CLEAR, ValueW'($urandom), 1'b0, '0);
      end else begin
        if (pick < 71) v = ValueW'(base + $urandom_range(BandW - 1));
        else if (pick < 86) v = ValueW'($urandom);
        else v = recent;
        offer_item(ACT_INSERT, v, 1'b0, '0);
        recent = v;
      end
    end
  endtask

  initial begin
    int unsigned perm [Window];
    int unsigned i, j, tmp;
    @(posedge clk iff rst_n);
    for (i = 0; i < NDir; i++) begin
      offer_item(DirRows[i].act, DirRows[i].val, DirRows[i].typed,
                 {DirRows[i].want_len, DirRows[i].want_new});
    end
    run_mixed(430);

    // hold the input until the block has drained
    in_valid <= 1'b0;
    wait (pending_runs.size() == 0);
    @(posedge clk);

    // fill the whole window in shuffled order, then clear it
    foreach (perm[k]) perm[k] = k;
    for (i = Window - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    foreach (perm[k]) offer_item(ACT_INSERT, ValueW'(perm[k]), 1'b0, '0);
    offer_item(ACT_CLEAR, ValueW'($urandom), 1'b0, '0);
    run_mixed(500);
    in_valid <= 1'b0;

    wait (pending_runs.size() == 0);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: check the beat, then pick the next ready level
  always @(posedge clk) begin
    run_result_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (pending_runs.size() == 0) begin
        flag_error($sformatf("unexpected result beat: longest_run=%0d was_new=%0b",
                             out_longest_run, out_was_new));
      end else begin
        want = pending_runs.pop_front();
        if (out_longest_run !== want.longest || out_was_new !== want.was_new) begin
          flag_error($sformatf("result %0d: longest_run exp %0d got %0d, was_new exp %0b got %0b",
                               beats_out, want.longest, out_longest_run,
                               want.was_new, out_was_new));
        end
      end
    end
    if (!hold_done && beats_out >= 300) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (beats_out >= 1300 && beats_out < 1600) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 38);
    end
  end

  // watchdog: count cycles in which neither channel moves a beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
